### src/rws_pkg.sv
// Shared types, codes and helpers for the retransmit window scheduler.
// Used by rws_slot_store and retransmit_window_scheduler_core; no dependencies.
package rws_pkg;

    localparam int ID_W   = 32;
    localparam int TYPE_W = 5;
    localparam int TO_W   = 16;
    localparam int WS_W   = 4;
    localparam int ACK_W  = 4;
    localparam int SLOT_W = 3;
    localparam int CFG_W  = 16;

    typedef enum logic [1:0] {
        OP_SUBMIT = 2'd0,
        OP_ACK    = 2'd1,
        OP_POLL   = 2'd2,
        OP_SCHED  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        CFG_INIT_TIMEOUT = 2'd0,
        CFG_WINDOW_SIZE  = 2'd1,
        CFG_HOLD_START   = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_ACT,
        S_SCAN2,
        S_DONE
    } t_state;

    typedef struct packed {
        logic              active;
        logic [ID_W-1:0]   id;
        logic [TYPE_W-1:0] mtype;
        logic [ID_W-1:0]   due;
        logic [ID_W-1:0]   backoff;
        logic [ACK_W-1:0]  acks;
    } t_entry;

    // True when a is older than b, taking id wraparound into account.
    function automatic logic id_older(input logic [ID_W-1:0] a, input logic [ID_W-1:0] b);
        logic [ID_W-1:0] d;
        d = a - b;
        return d[ID_W-1];
    endfunction

endpackage

### src/rws_slot_store.sv
// Slot table of the retransmit window: per-slot id, type, timing and ack count.
// Depends on rws_pkg for the entry type.
module rws_slot_store #(
    parameter int SLOTS = 8,
    parameter int IDX_W = 3
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [IDX_W-1:0]  i_rd_idx,
    output rws_pkg::t_entry   o_rd,
    input  logic              i_wr_en,
    input  logic [IDX_W-1:0]  i_wr_idx,
    input  rws_pkg::t_entry   i_wr
);
    import rws_pkg::*;

    logic [SLOTS-1:0]  r_active;
    logic [ID_W-1:0]   r_id      [SLOTS];
    logic [TYPE_W-1:0] r_mtype   [SLOTS];
    logic [ID_W-1:0]   r_due     [SLOTS];
    logic [ID_W-1:0]   r_backoff [SLOTS];
    logic [ACK_W-1:0]  r_acks    [SLOTS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
        end else if (i_wr_en) begin
            r_active[i_wr_idx] <= i_wr.active;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_id[i_wr_idx]      <= i_wr.id;
            r_mtype[i_wr_idx]   <= i_wr.mtype;
            r_due[i_wr_idx]     <= i_wr.due;
            r_backoff[i_wr_idx] <= i_wr.backoff;
            r_acks[i_wr_idx]    <= i_wr.acks;
        end
    end

    always_comb begin
        o_rd.active  = r_active[i_rd_idx];
        o_rd.id      = r_id[i_rd_idx];
        o_rd.mtype   = r_mtype[i_rd_idx];
        o_rd.due     = r_due[i_rd_idx];
        o_rd.backoff = r_backoff[i_rd_idx];
        o_rd.acks    = r_acks[i_rd_idx];
    end

endmodule

### src/retransmit_window_scheduler_core.sv
// Retransmit window scheduler: each request is submit, ack, poll or schedule-now,
// and gives one result. A request runs two passes of the single slot-evaluation
// unit over the first N slots of the table, N being the clamped window size
// (one slot per cycle: the operation pass, then the wait/ready pass), with an
// update step between the passes and an output step after them. The input is not
// ready while a request is in work; a finished result waits in an output register
// so the next request can be taken meanwhile. Depends on rws_pkg, rws_slot_store.
module retransmit_window_scheduler_core #(
    parameter int SLOTS              = 8,
    parameter int ACKS_BEFORE_RESEND = 3
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // now_seconds[31:0], acked_id[63:32], msg_type[68:64], zero fill
    input  logic [71:0]                s_axis_tdata,
    // op[1:0]
    input  logic [1:0]                 s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // done_res[0], slot[3:1], out_id[35:4], out_type[40:36],
    // wait_seconds[72:41], send_ready[73], zero fill
    output logic [79:0]                m_axis_tdata,
    input  logic                       i_cfg_we,
    input  logic [1:0]                 i_cfg_addr,
    input  logic [rws_pkg::CFG_W-1:0]  i_cfg_data
);
    import rws_pkg::*;

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);

    t_state r_state, n_state;

    logic [TO_W-1:0]   r_init_to;
    logic [WS_W-1:0]   r_win;
    logic              r_hold;
    logic [ID_W-1:0]   r_next_id;

    t_op               r_op;
    logic [ID_W-1:0]   r_now;
    logic [ID_W-1:0]   r_acked;
    logic [TYPE_W-1:0] r_type;
    logic [CNT_W-1:0]  r_n;
    logic [IDX_W-1:0]  r_idx;

    logic              r_have_min, r_have_free, r_found;
    logic [ID_W-1:0]   r_min_id;
    logic [IDX_W-1:0]  r_free_idx, r_best_idx;
    logic [ID_W-1:0]   r_best_id, r_best_backoff;
    logic [TYPE_W-1:0] r_best_type;

    logic              r_done;
    logic [SLOT_W-1:0] r_slot;
    logic [ID_W-1:0]   r_oid;
    logic [TYPE_W-1:0] r_otype;
    logic [ID_W-1:0]   r_wait;
    logic              r_ready;

    logic              r_ov;
    logic [79:0]       r_odata;

    t_entry            rd, wr;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_idx;

    logic              in_acc, last, due_now, submit_ok, load_out;
    logic [ID_W:0]     due_sum;
    logic [ID_W-1:0]   span;
    logic [WS_W:0]     n_clamp;

    rws_slot_store #(.SLOTS(SLOTS), .IDX_W(IDX_W)) u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_idx (r_idx),
        .o_rd     (rd),
        .i_wr_en  (wr_en),
        .i_wr_idx (wr_idx),
        .i_wr     (wr)
    );

    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign last     = ({1'b0, r_idx} == (r_n - CNT_W'(1)));
    assign due_now  = rd.active &&
                      ((r_now >= rd.due) || (rd.acks >= ACK_W'(ACKS_BEFORE_RESEND)));
    assign span     = r_next_id - r_min_id;
    assign submit_ok = r_have_free && (!r_have_min || (span < ID_W'(r_n)));
    assign due_sum  = {1'b0, r_now} + {1'b0, r_best_backoff};
    assign load_out = (r_state == S_DONE) && (!r_ov || m_axis_tready);

    always_comb begin
        if (r_win == '0) begin
            n_clamp = (WS_W+1)'(1);
        end else if ({1'b0, r_win} > (WS_W+1)'(SLOTS)) begin
            n_clamp = (WS_W+1)'(SLOTS);
        end else begin
            n_clamp = {1'b0, r_win};
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (in_acc) n_state = S_SCAN;
            S_SCAN:  if (last) n_state = S_ACT;
            S_ACT:   n_state = S_SCAN2;
            S_SCAN2: if (last) n_state = S_DONE;
            S_DONE:  if (load_out) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Table write port and handshake outputs
    always_comb begin
        s_axis_tready = (r_state == S_IDLE);
        wr_en  = 1'b0;
        wr_idx = r_idx;
        wr     = rd;
        case (r_state)
            S_SCAN: begin
                if (r_op == OP_ACK && rd.active) begin
                    wr_en = 1'b1;
                    if (rd.id == r_acked) begin
                        wr.active = 1'b0;
                    end else if (rd.id < r_acked && rd.acks != '1) begin
                        wr.acks = rd.acks + ACK_W'(1);
                    end
                end else if (r_op == OP_SCHED && rd.active) begin
                    wr_en      = 1'b1;
                    wr.due     = r_now;
                    wr.backoff = ID_W'(r_init_to);
                end
            end
            S_ACT: begin
                if (r_op == OP_SUBMIT) begin
                    wr_en      = submit_ok;
                    wr_idx     = r_free_idx;
                    wr.active  = 1'b1;
                    wr.id      = r_next_id;
                    wr.mtype   = r_type;
                    wr.due     = '0;
                    wr.backoff = ID_W'(r_init_to);
                    wr.acks    = '0;
                end else if (r_op == OP_POLL) begin
                    wr_en      = r_found;
                    wr_idx     = r_best_idx;
                    wr.active  = 1'b1;
                    wr.id      = r_best_id;
                    wr.mtype   = r_best_type;
                    wr.due     = due_sum[ID_W] ? '1 : due_sum[ID_W-1:0];
                    wr.backoff = r_best_backoff[ID_W-1] ? '1 : {r_best_backoff[ID_W-2:0], 1'b0};
                    wr.acks    = '0;
                end
            end
            default: wr_en = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration, hold flag and sequence counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_to <= TO_W'(2);
            r_win     <= WS_W'(4);
            r_hold    <= 1'b0;
            r_next_id <= '0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_addr))
                    CFG_INIT_TIMEOUT: r_init_to <= i_cfg_data[TO_W-1:0];
                    CFG_WINDOW_SIZE:  r_win     <= i_cfg_data[WS_W-1:0];
                    CFG_HOLD_START:   r_hold    <= i_cfg_data[0];
                    default: ;
                endcase
            end else if (r_state == S_ACT && r_op == OP_SCHED) begin
                r_hold <= 1'b0;
            end
            if (r_state == S_ACT && r_op == OP_SUBMIT && submit_ok) begin
                r_next_id <= r_next_id + ID_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (in_acc || r_state == S_ACT || last) begin
            r_idx <= '0;
        end else if (r_state == S_SCAN || r_state == S_SCAN2) begin
            r_idx <= r_idx + IDX_W'(1);
        end
    end

    // Request capture and the per-slot evaluation accumulators
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op        <= t_op'(s_axis_tuser);
            r_now       <= s_axis_tdata[31:0];
            r_acked     <= s_axis_tdata[63:32];
            r_type      <= s_axis_tdata[68:64];
            r_n         <= CNT_W'(n_clamp);
            r_have_min  <= 1'b0;
            r_have_free <= 1'b0;
            r_found     <= 1'b0;
            r_wait      <= '1;
            r_ready     <= 1'b0;
        end
        if (r_state == S_SCAN) begin
            if (rd.active) begin
                if (!r_have_min || id_older(rd.id, r_min_id)) begin
                    r_have_min <= 1'b1;
                    r_min_id   <= rd.id;
                end
            end else if (!r_have_free) begin
                r_have_free <= 1'b1;
                r_free_idx  <= r_idx;
            end
            if (due_now && (!r_found || id_older(rd.id, r_best_id))) begin
                r_found        <= 1'b1;
                r_best_idx     <= r_idx;
                r_best_id      <= rd.id;
                r_best_type    <= rd.mtype;
                r_best_backoff <= rd.backoff;
            end
        end
        if (r_state == S_ACT) begin
            r_done  <= 1'b0;
            r_slot  <= '0;
            r_oid   <= '0;
            r_otype <= '0;
            if (r_op == OP_SUBMIT && submit_ok) begin
                r_done <= 1'b1;
                r_slot <= SLOT_W'(r_free_idx);
                r_oid  <= r_next_id;
            end else if (r_op == OP_POLL && r_found) begin
                r_done  <= 1'b1;
                r_slot  <= SLOT_W'(r_best_idx);
                r_oid   <= r_best_id;
                r_otype <= r_best_type;
            end
        end
        if (r_state == S_SCAN2 && rd.active) begin
            if (due_now) begin
                r_ready <= 1'b1;
            end
            if (rd.due <= r_now) begin
                r_wait <= '0;
            end else if ((rd.due - r_now) < r_wait) begin
                r_wait <= rd.due - r_now;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (load_out) begin
            r_ov <= 1'b1;
        end else if (m_axis_tready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_odata <= {6'd0, r_ready && !r_hold, r_wait, r_otype, r_oid, r_slot, r_done};
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_odata;

endmodule

### dv/retransmit_window_scheduler_core_tb.sv
// Self-checking testbench for retransmit_window_scheduler_core: directed and random
// submit/ack/poll/schedule-now requests checked against a cycle-free model of the window.
// Depends on rws_pkg and the scheduler RTL.
`timescale 1ns / 100ps

module retransmit_window_scheduler_core_tb;
    import rws_pkg::*;

    localparam int NSLOT = 8;
    localparam int ACK_LIMIT = 3;

    typedef struct {
        t_op         op;
        logic [31:0] now;
        logic [31:0] acked;
        logic [4:0]  mtype;
    } t_req;

    typedef struct {
        logic        done;
        logic [2:0]  slot;
        logic [31:0] id;
        logic [4:0]  otype;
        logic [31:0] wait_s;
        logic        ready;
    } t_rsp;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [79:0] m_axis_tdata;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_addr;
    logic [15:0] i_cfg_data;

    retransmit_window_scheduler_core i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .i_cfg_we(i_cfg_we), .i_cfg_addr(i_cfg_addr), .i_cfg_data(i_cfg_data)
    );

    always begin
        i_clk = 1'b1; #4;
        i_clk = 1'b0; #4;
    end

    // Window model state.
    logic        win_active [NSLOT];
    logic [31:0] win_id [NSLOT];
    logic [4:0]  win_type [NSLOT];
    logic [31:0] win_due [NSLOT];
    logic [31:0] win_backoff [NSLOT];
    logic [3:0]  win_acks [NSLOT];
    logic [31:0] win_next_id;
    logic        win_hold;
    logic [15:0] cfg_timeout;
    logic [3:0]  cfg_window;

    t_req pending_reqs[$];
    t_rsp expected_rsps[$];
    t_req cur_req;
    int   send_idle_pct, recv_idle_pct;
    int   errors, n_checked, n_done;
    int   op_count [4];
    logic [31:0] gen_now;

    function automatic logic older(logic [31:0] a, logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return d[31];
    endfunction

    function automatic logic slot_is_due(int i, logic [31:0] now);
        return win_active[i] && (now >= win_due[i] || win_acks[i] >= ACK_LIMIT);
    endfunction

    function automatic void predict_window(t_req r);
        int n, i, free_slot, best;
        logic have_min, have_free, found;
        logic [31:0] min_id, d;
        logic [32:0] sum;
        t_rsp e;
        n = (cfg_window == 0) ? 1 : (cfg_window > NSLOT) ? NSLOT : cfg_window;
        e = '{done: 0, slot: 0, id: 0, otype: 0, wait_s: '1, ready: 0};
        op_count[r.op]++;
        case (r.op)
            OP_SUBMIT: begin
                have_min = 0; have_free = 0; min_id = 0; free_slot = 0;
                for (i = 0; i < n; i++) begin
                    if (win_active[i]) begin
                        if (!have_min || older(win_id[i], min_id)) begin
                            have_min = 1; min_id = win_id[i];
                        end
                    end else if (!have_free) begin
                        have_free = 1; free_slot = i;
                    end
                end
                d = win_next_id - min_id;
                if (have_free && (!have_min || d < n)) begin
                    win_active[free_slot] = 1;
                    win_id[free_slot] = win_next_id;
                    win_type[free_slot] = r.mtype;
                    win_due[free_slot] = 0;
                    win_backoff[free_slot] = {16'd0, cfg_timeout};
                    win_acks[free_slot] = 0;
                    e.done = 1; e.slot = free_slot[2:0]; e.id = win_next_id;
                    win_next_id++;
                end
            end
            OP_ACK: begin
                for (i = 0; i < n; i++) begin
                    if (win_active[i]) begin
                        if (win_id[i] == r.acked) win_active[i] = 0;
                        else if (win_id[i] < r.acked && win_acks[i] != 4'd15) win_acks[i]++;
                    end
                end
            end
            OP_POLL: begin
                found = 0; best = 0;
                for (i = 0; i < n; i++) begin
                    if (slot_is_due(i, r.now) && (!found || older(win_id[i], win_id[best]))) begin
                        found = 1; best = i;
                    end
                end
                if (found) begin
                    sum = {1'b0, r.now} + {1'b0, win_backoff[best]};
                    win_due[best] = sum[32] ? '1 : sum[31:0];
                    win_backoff[best] = win_backoff[best][31] ? '1 : win_backoff[best] << 1;
                    win_acks[best] = 0;
                    e.done = 1; e.slot = best[2:0]; e.id = win_id[best];
                    e.otype = win_type[best];
                end
            end
            default: begin
                win_hold = 0;
                for (i = 0; i < n; i++) begin
                    if (win_active[i]) begin
                        win_due[i] = r.now;
                        win_backoff[i] = {16'd0, cfg_timeout};
                    end
                end
            end
        endcase
        for (i = 0; i < n; i++) begin
            if (win_active[i]) begin
                if (slot_is_due(i, r.now)) e.ready = 1;
                if (win_due[i] <= r.now) e.wait_s = 0;
                else if (win_due[i] - r.now < e.wait_s) e.wait_s = win_due[i] - r.now;
            end
        end
        e.ready = e.ready && !win_hold;
        expected_rsps.push_back(e);
    endfunction

    // Request driver.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (s_axis_tvalid) predict_window(cur_req);
            if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                cur_req = pending_reqs.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {3'd0, cur_req.mtype, cur_req.acked, cur_req.now};
                s_axis_tuser <= cur_req.op;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch on result %0d: %s got %0h expected %0h", n_checked, what, got, want);
        errors++;
    endtask

    // Result monitor.
    always @(posedge i_clk) begin
        t_rsp e;
        m_axis_tready <= i_rst_n && ($urandom_range(99) >= recv_idle_pct);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_rsps.size() == 0) begin
                $display("unexpected result %0h", m_axis_tdata);
                errors++;
            end else begin
                e = expected_rsps.pop_front();
                if (m_axis_tdata[0] !== e.done) report("done_res", m_axis_tdata[0], e.done);
                if (m_axis_tdata[3:1] !== e.slot) report("slot", m_axis_tdata[3:1], e.slot);
                if (m_axis_tdata[35:4] !== e.id) report("out_id", m_axis_tdata[35:4], e.id);
                if (m_axis_tdata[40:36] !== e.otype)
                    report("out_type", m_axis_tdata[40:36], e.otype);
                if (m_axis_tdata[72:41] !== e.wait_s)
                    report("wait_seconds", m_axis_tdata[72:41], e.wait_s);
                if (m_axis_tdata[73] !== e.ready) report("send_ready", m_axis_tdata[73], e.ready);
                if (e.done) n_done++;
                n_checked++;
            end
        end
    end

    task automatic add_req(t_op op, logic [31:0] dt, logic [31:0] acked, logic [4:0] mtype);
        gen_now = gen_now + dt;
        pending_reqs.push_back('{op: op, now: gen_now, acked: acked, mtype: mtype});
    endtask

    task automatic wait_idle();
        while (pending_reqs.size() != 0 || expected_rsps.size() != 0 || s_axis_tvalid)
            @(negedge i_clk);
        repeat (30) @(negedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [15:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_INIT_TIMEOUT: cfg_timeout = val;
            CFG_WINDOW_SIZE:  cfg_window = val[3:0];
            default:          win_hold = val[0];
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Mostly well-formed traffic: acks aimed at recent ids, polls, a few schedule-nows.
    task automatic random_traffic(int count);
        int k, pick;
        logic [31:0] dt, acked;
        for (k = 0; k < count; k++) begin
            while (pending_reqs.size() > 1) @(negedge i_clk);
            pick = $urandom_range(99);
            dt = ($urandom_range(19) == 0) ? $urandom_range(70000) : $urandom_range(3);
            case ($urandom_range(9))
                0: acked = $urandom;
                1: acked = win_next_id + $urandom_range(20);
                default: acked = win_next_id - $urandom_range(1, 9);
            endcase
            if (pick < 35) add_req(OP_SUBMIT, dt, $urandom, $urandom);
            else if (pick < 60) add_req(OP_ACK, dt, acked, $urandom);
            else if (pick < 92) add_req(OP_POLL, dt, $urandom, $urandom);
            else add_req(OP_SCHED, dt, $urandom, $urandom);
        end
        wait_idle();
    endtask

    initial begin
        int k;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        m_axis_tready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_addr = '0;
        i_cfg_data = '0;
        errors = 0; n_checked = 0; n_done = 0;
        op_count = '{0, 0, 0, 0};
        gen_now = 0;
        send_idle_pct = 28; recv_idle_pct = 80;
        for (k = 0; k < NSLOT; k++) win_active[k] = 0;
        win_next_id = 0; win_hold = 0; cfg_timeout = 2; cfg_window = 4;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: fill the window, overflow, polls, acks, schedule-now, count trigger.
        add_req(OP_SUBMIT, 0, 0, 5'd31);
        add_req(OP_SUBMIT, 0, 0, 5'd0);
        add_req(OP_SUBMIT, 0, '1, 5'd10);
        add_req(OP_SUBMIT, 0, 0, 5'd21);
        add_req(OP_SUBMIT, 0, 0, 5'd7);
        add_req(OP_POLL, 0, 0, 0);
        add_req(OP_POLL, 0, 0, 0);
        add_req(OP_ACK, 1, 32'd1, 0);
        add_req(OP_POLL, 1, 0, 0);
        add_req(OP_SCHED, 3, 0, 0);
        add_req(OP_POLL, 0, 0, 0);
        add_req(OP_ACK, 0, 32'd9, 0);
        add_req(OP_ACK, 0, 32'd9, 0);
        add_req(OP_ACK, 0, 32'd9, 0);
        add_req(OP_POLL, 0, 0, 0);
        add_req(OP_SUBMIT, 0, 0, 5'd3);
        add_req(OP_ACK, 0, '1, 0);
        add_req(OP_POLL, 100, 0, 0);
        add_req(OP_POLL, 0, 0, 0);
        add_req(OP_ACK, 0, 32'd0, 0);
        wait_idle();
        random_traffic(190);

        write_reg(CFG_INIT_TIMEOUT, 16'hFFFF);
        write_reg(CFG_WINDOW_SIZE, 16'd8);
        write_reg(CFG_HOLD_START, 16'd1);
        random_traffic(190);

        send_idle_pct = 80; recv_idle_pct = 28;
        write_reg(CFG_INIT_TIMEOUT, 16'd0);
        write_reg(CFG_WINDOW_SIZE, 16'd1);
        random_traffic(190);
        write_reg(CFG_INIT_TIMEOUT, 16'd1);
        write_reg(CFG_WINDOW_SIZE, 16'd15);
        write_reg(CFG_HOLD_START, 16'd0);
        random_traffic(190);

        send_idle_pct = 0; recv_idle_pct = 0;
        write_reg(CFG_INIT_TIMEOUT, 16'd3);
        write_reg(CFG_WINDOW_SIZE, 16'd0);
        random_traffic(190);
        // Close to the top of the time range, so due times saturate.
        write_reg(CFG_INIT_TIMEOUT, 16'd7);
        write_reg(CFG_WINDOW_SIZE, 16'd6);
        write_reg(CFG_HOLD_START, 16'd1);
        gen_now = 32'hFFFF_FF00;
        random_traffic(190);

        $display("ran %0d submits, %0d acks, %0d polls, %0d schedule-nows",
                 op_count[0], op_count[1], op_count[2], op_count[3]);
        $display("checked %0d results, %0d with done set, over six register settings",
                 n_checked, n_done);
        if (errors == 0) begin
            $display("** retransmit_window_scheduler_core: PASSED **");
        end else begin
            $display("** retransmit_window_scheduler_core: FAILED **");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("timeout with %0d requests outstanding", expected_rsps.size());
        $display("** retransmit_window_scheduler_core: FAILED **");
        $finish;
    end

endmodule
